// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the rtl, sampled on clock and muted during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge
`define CHK_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define CHK_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/i2cms_pkg.sv =====
// ---------------------------------------------------------------------------
// i2cms_pkg
// types, codes and fixed constants of the i2c master transaction sequencer
// ---------------------------------------------------------------------------
package i2cms_pkg;

   // request modes
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_STATUS = 2'd2;

   // twi status codes, prescaler bits masked off
   localparam logic [7:0] STATUS_MASK      = 8'hF8;
   localparam logic [7:0] TWI_BUS_ERROR    = 8'h00;
   localparam logic [7:0] TWI_START        = 8'h08;
   localparam logic [7:0] TWI_REP_START    = 8'h10;
   localparam logic [7:0] TWI_MT_SLA_ACK   = 8'h18;
   localparam logic [7:0] TWI_MT_SLA_NACK  = 8'h20;
   localparam logic [7:0] TWI_MT_DATA_ACK  = 8'h28;
   localparam logic [7:0] TWI_MT_DATA_NACK = 8'h30;
   localparam logic [7:0] TWI_ARB_LOST     = 8'h38;
   localparam logic [7:0] TWI_MR_SLA_ACK   = 8'h40;
   localparam logic [7:0] TWI_MR_SLA_NACK  = 8'h48;
   localparam logic [7:0] TWI_MR_DATA_ACK  = 8'h50;
   localparam logic [7:0] TWI_MR_DATA_NACK = 8'h58;

   // read dump limits
   localparam int DUMP_W      = 5;
   localparam int MAX_RESULTS = 16;

   // command queue geometry
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef enum logic [1:0] {
      PH_READY,
      PH_TRANSMIT,
      PH_RECEIVE
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_ACK,
      ACT_NACK,
      ACT_STOP,
      ACT_RELEASE,
      ACT_START
   } act_type;

   typedef enum logic [1:0] {
      EV_NONE,
      EV_WRITE,
      EV_READ_OK,
      EV_READ_FAIL
   } ev_type;

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_START,
      CMD_ADDR,
      CMD_TX_NEXT,
      CMD_STOP_WR,
      CMD_RELEASE,
      CMD_RX_MORE,
      CMD_RX_FAIL,
      CMD_RX_DONE,
      CMD_BUS_ERR
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_DUMP_RD,
      BK_DUMP_OUT
   } back_state_type;

   // classified item as it sits in the queue
   typedef struct packed {
      cmd_type    cmd;
      logic       store;
      logic [6:0] dev_address;
      logic       read_not_write;
      logic [4:0] transfer_length;
      logic [3:0] buffer_slot;
      logic [7:0] byte_value;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   typedef struct packed {
      logic       accepted;
      act_type    bus_action;
      logic       tx_valid;
      logic [7:0] tx_byte;
      ev_type     event_res;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       last;
   } rsp_type;

endpackage

// ===== rtl/core/i2c_master_transaction_sequencer.sv =====
// ---------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// byte level i2c master sequencer driven by twi status codes
// ---------------------------------------------------------------------------
// usage:
//   req_* channel: one item loads a write byte, starts a transfer or reports
//   a bus status with the received byte; accepted when req_valid is high and
//   req_stall is low
//   rsp_* channel: one item per request, or a run of buffer bytes after a
//   successful read (rsp_last marks the final one); the block holds rsp_valid
//   and the payload while rsp_stall is high
//   csr_* channel: writes callback_mode; csr_ready is always high, write only
//   while no request is in flight
//   flow: an accepted request passes the queue, then the back end idle state,
//   which issues the buffer read, then the execute state, which registers the
//   response; the back end takes the next request only after that, and a read
//   dump alternates a read state and an output state per byte on that read port
//   the two entry command queue lets requests keep arriving while the back
//   end waits on a stalled response
//   reset: synchronous; phase returns to ready, position, count and address
//   clear, the queue empties; buffer contents stay undefined until written
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_transaction_sequencer
   import i2cms_pkg::*;
#(
   parameter int BUFFER_DEPTH = 16
)
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [6:0] req_dev_address,
   input  logic       req_read_not_write,
   input  logic [4:0] req_transfer_length,
   input  logic [3:0] req_buffer_slot,
   input  logic [7:0] req_byte_value,
   input  logic [7:0] req_status_code,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_accepted,
   output logic [2:0] rsp_bus_action,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic [1:0] rsp_event_res,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_last,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_callback_mode
);

   // configuration register
   logic       callback_mode_ff;

   // front to queue
   logic       push;
   entry_type  push_entry;
   q_stat_type q_stat;

   // queue to back
   entry_type  head;
   logic       pop;
   rsp_type    rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         callback_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         callback_mode_ff <= csr_callback_mode;
      end
   end

   // front: take and classify request items
   i2cms_front u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_dev_address     (req_dev_address),
      .req_read_not_write  (req_read_not_write),
      .req_transfer_length (req_transfer_length),
      .req_buffer_slot     (req_buffer_slot),
      .req_byte_value      (req_byte_value),
      .req_status_code     (req_status_code),
      .q_stat              (q_stat),
      .push                (push),
      .push_entry          (push_entry)
   );

   // queue: decouples front and back
   i2cms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // back: transfer state, byte buffer and response register
   i2cms_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .callback_mode (callback_mode_ff),
      .head          (head),
      .q_empty       (q_stat.empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp           (rsp)
   );

   assign rsp_accepted   = rsp.accepted;
   assign rsp_bus_action = rsp.bus_action;
   assign rsp_tx_valid   = rsp.tx_valid;
   assign rsp_tx_byte    = rsp.tx_byte;
   assign rsp_event_res  = rsp.event_res;
   assign rsp_rx_valid   = rsp.rx_valid;
   assign rsp_rx_byte    = rsp.rx_byte;
   assign rsp_last       = rsp.last;

   // only read dumps produce more than one response item per request
   `CHK_IMPLY(a_multi_only_dump, rsp_valid && !rsp_last, rsp_rx_valid, "non-final item outside dump")

   // a buffer byte item never carries a transmit byte or an acceptance
   `CHK_IMPLY(a_rx_exclusive, rsp_valid && rsp_rx_valid, !rsp_tx_valid && !rsp_accepted, "rx item mixed")

   // load and start responses are always single items
   `CHK_IMPLY(a_accept_single, rsp_valid && rsp_accepted, rsp_last && !rsp_tx_valid, "bad accept item")

endmodule

// ===== rtl/core/i2cms_front.sv =====
// ---------------------------------------------------------------------------
// i2cms_front
// takes request items and classifies them into queue commands
// ---------------------------------------------------------------------------
module i2cms_front
   import i2cms_pkg::*;
(
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [6:0] req_dev_address,
   input  logic       req_read_not_write,
   input  logic [4:0] req_transfer_length,
   input  logic [3:0] req_buffer_slot,
   input  logic [7:0] req_byte_value,
   input  logic [7:0] req_status_code,
   input  q_stat_type q_stat,
   output logic       push,
   output entry_type  push_entry
);

   logic [7:0] status;
   cmd_type    cmd;
   logic       store;

   assign status = req_status_code & STATUS_MASK;

   always_comb begin
      cmd   = CMD_NOP;
      store = 1'b0;
      case (req_mode)
         MODE_LOAD: begin
            cmd = CMD_LOAD;
         end
         MODE_START: begin
            cmd = CMD_START;
         end
         MODE_STATUS: begin
            case (status)
               TWI_START, TWI_REP_START:           cmd = CMD_ADDR;
               TWI_MT_SLA_ACK, TWI_MT_DATA_ACK:    cmd = CMD_TX_NEXT;
               TWI_MT_SLA_NACK, TWI_MT_DATA_NACK:  cmd = CMD_STOP_WR;
               TWI_ARB_LOST:                       cmd = CMD_RELEASE;
               TWI_MR_SLA_ACK: begin
                  cmd = CMD_RX_MORE;
               end
               TWI_MR_DATA_ACK: begin
                  cmd   = CMD_RX_MORE;
                  store = 1'b1;
               end
               TWI_MR_SLA_NACK:                    cmd = CMD_RX_FAIL;
               TWI_MR_DATA_NACK: begin
                  cmd   = CMD_RX_DONE;
                  store = 1'b1;
               end
               TWI_BUS_ERROR:                      cmd = CMD_BUS_ERR;
               default:                            cmd = CMD_NOP;
            endcase
         end
         default: begin
            cmd = CMD_NOP;
         end
      endcase
   end

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   assign push_entry.cmd             = cmd;
   assign push_entry.store           = store;
   assign push_entry.dev_address     = req_dev_address;
   assign push_entry.read_not_write  = req_read_not_write;
   assign push_entry.transfer_length = req_transfer_length;
   assign push_entry.buffer_slot     = req_buffer_slot;
   assign push_entry.byte_value      = req_byte_value;

endmodule

// ===== rtl/core/i2cms_queue.sv =====
// ---------------------------------------------------------------------------
// i2cms_queue
// short command queue between front and back
// ---------------------------------------------------------------------------
module i2cms_queue
   import i2cms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   input  logic       pop,
   output entry_type  head,
   output q_stat_type q_stat
);

   entry_type           slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff;
   logic [Q_PTR_W-1:0]  wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff;
   logic [Q_PTR_W-1:0]  rd_ptr_in;
   logic [Q_CNT_W-1:0]  count_ff;
   logic [Q_CNT_W-1:0]  count_in;
   logic                do_push;
   logic                do_pop;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign head         = slot_ff[rd_ptr_ff];

   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/i2cms_back.sv =====
// ---------------------------------------------------------------------------
// i2cms_back
// executes queued commands: transfer state, byte buffer, response register
// ---------------------------------------------------------------------------
module i2cms_back
   import i2cms_pkg::*;
#(
   parameter int BUFFER_DEPTH = 16
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      callback_mode,
   input  entry_type head,
   input  logic      q_empty,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int PW = $clog2(BUFFER_DEPTH + 1);

   back_state_type    state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [4:0]        count_ff, count_in;
   logic [7:0]        addr_rw_ff, addr_rw_in;
   logic [DUMP_W-1:0] dump_idx_ff, dump_idx_in;
   logic [DUMP_W-1:0] dump_n_ff, dump_n_in;

   logic [7:0]        buf_mem [BUFFER_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [7:0]        mem_wd;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic              out_load;
   rsp_type           out_data;
   logic              out_free;

   logic              pos_room;
   logic              slot_ok;
   logic              len_ok;
   logic              do_store;
   logic [PW-1:0]     rx_pos;
   logic              rx_ack;
   logic [DUMP_W-1:0] dump_n;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pos_room = (32'(pos_ff) < BUFFER_DEPTH);
   assign slot_ok  = (32'(head.buffer_slot) < BUFFER_DEPTH);
   assign len_ok   = (32'(head.transfer_length) <= BUFFER_DEPTH);
   assign do_store = head.store && pos_room;
   assign rx_pos   = do_store ? pos_ff + PW'(1) : pos_ff;
   assign rx_ack   = (32'(rx_pos) + 32'd1 < 32'(count_ff));
   assign dump_n   = (32'(count_ff) > MAX_RESULTS) ? DUMP_W'(MAX_RESULTS)
                                                   : DUMP_W'(count_ff);

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      addr_rw_in  = addr_rw_ff;
      dump_idx_in = dump_idx_ff;
      dump_n_in   = dump_n_ff;
      pop         = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = AW'(pos_ff);
      mem_wd      = head.byte_value;
      rd_addr     = AW'(pos_ff);
      out_load    = 1'b0;
      out_data    = '0;
      out_data.bus_action = ACT_NONE;
      out_data.event_res  = EV_NONE;
      out_data.last       = 1'b1;

      case (state_ff)
         BK_IDLE: begin
            // buffer read at the current position is issued here
            if (!q_empty) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (out_free) begin
               pop      = 1'b1;
               out_load = 1'b1;
               state_in = BK_IDLE;
               case (head.cmd)
                  CMD_LOAD: begin
                     if (phase_ff == PH_READY && slot_ok) begin
                        mem_we            = 1'b1;
                        mem_wa            = AW'(head.buffer_slot);
                        out_data.accepted = 1'b1;
                     end
                  end
                  CMD_START: begin
                     if (phase_ff == PH_READY && len_ok) begin
                        phase_in = head.read_not_write ? PH_RECEIVE : PH_TRANSMIT;
                        pos_in   = '0;
                        count_in = head.transfer_length;
                        addr_rw_in = {head.dev_address, head.read_not_write};
                        out_data.accepted   = 1'b1;
                        out_data.bus_action = ACT_START;
                     end
                  end
                  CMD_ADDR: begin
                     out_data.bus_action = ACT_ACK;
                     out_data.tx_valid   = 1'b1;
                     out_data.tx_byte    = addr_rw_ff;
                  end
                  CMD_TX_NEXT: begin
                     if (32'(pos_ff) < 32'(count_ff) && pos_room) begin
                        pos_in              = pos_ff + PW'(1);
                        out_data.bus_action = ACT_ACK;
                        out_data.tx_valid   = 1'b1;
                        out_data.tx_byte    = rd_data_ff;
                     end else begin
                        phase_in            = PH_READY;
                        out_data.bus_action = ACT_STOP;
                        out_data.event_res  = callback_mode ? EV_WRITE : EV_NONE;
                     end
                  end
                  CMD_STOP_WR: begin
                     phase_in            = PH_READY;
                     out_data.bus_action = ACT_STOP;
                     out_data.event_res  = callback_mode ? EV_WRITE : EV_NONE;
                  end
                  CMD_RELEASE: begin
                     phase_in            = PH_READY;
                     out_data.bus_action = ACT_RELEASE;
                     out_data.event_res  = callback_mode ? EV_WRITE : EV_NONE;
                  end
                  CMD_RX_MORE: begin
                     mem_we              = do_store;
                     pos_in              = rx_pos;
                     out_data.bus_action = rx_ack ? ACT_ACK : ACT_NACK;
                  end
                  CMD_RX_FAIL: begin
                     phase_in            = PH_READY;
                     out_data.bus_action = ACT_STOP;
                     out_data.event_res  = callback_mode ? EV_READ_FAIL : EV_NONE;
                  end
                  CMD_RX_DONE: begin
                     mem_we   = do_store;
                     pos_in   = rx_pos;
                     phase_in = PH_READY;
                     if (dump_n == '0) begin
                        out_data.bus_action = ACT_STOP;
                        out_data.event_res  = callback_mode ? EV_READ_OK : EV_NONE;
                     end else begin
                        // results come from the dump states instead
                        out_load    = 1'b0;
                        dump_idx_in = '0;
                        dump_n_in   = dump_n;
                        state_in    = BK_DUMP_RD;
                     end
                  end
                  CMD_BUS_ERR: begin
                     phase_in            = PH_READY;
                     out_data.bus_action = ACT_STOP;
                  end
                  default: begin
                     out_data.bus_action = ACT_NONE;
                  end
               endcase
            end
         end
         BK_DUMP_RD: begin
            rd_addr  = AW'(dump_idx_ff);
            state_in = BK_DUMP_OUT;
         end
         BK_DUMP_OUT: begin
            rd_addr = AW'(dump_idx_ff);
            if (out_free) begin
               out_load          = 1'b1;
               out_data.rx_valid = 1'b1;
               out_data.rx_byte  = rd_data_ff;
               out_data.last     = (dump_idx_ff + DUMP_W'(1) == dump_n_ff);
               if (dump_idx_ff == '0) begin
                  out_data.bus_action = ACT_STOP;
                  out_data.event_res  = callback_mode ? EV_READ_OK : EV_NONE;
               end
               dump_idx_in = dump_idx_ff + DUMP_W'(1);
               state_in    = out_data.last ? BK_IDLE : BK_DUMP_RD;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         phase_ff     <= PH_READY;
         pos_ff       <= '0;
         count_ff     <= '0;
         addr_rw_ff   <= '0;
         dump_idx_ff  <= '0;
         dump_n_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         count_ff    <= count_in;
         addr_rw_ff  <= addr_rw_in;
         dump_idx_ff <= dump_idx_in;
         dump_n_ff   <= dump_n_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // byte buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= buf_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= out_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== tb/sv/i2c_master_transaction_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// i2c_master_transaction_sequencer_tb
// self-checking bench: a queue-fed driver pushes loads, starts and twi status
// items through the req channel; a clocked monitor predicts every response
// item from its own copy of the sequencer state and checks the rsp channel
// field by field against the oldest prediction, under random idling and
// stalls, across both callback_mode settings
// ---------------------------------------------------------------------------
module i2c_master_transaction_sequencer_tb;
   import i2cms_pkg::*;

   localparam int BUFFER_DEPTH    = 16;
   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 20;
   localparam int IDLE_LIMIT      = 4000;
   localparam int ITEMS_PER_SETTING = 120;

   // mode value with no function in the block
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // twi "no relevant state" code, no action expected
   localparam logic [7:0] TWI_NO_INFO = 8'hF8;

   typedef struct {
      logic [1:0] mode;
      logic [6:0] dev_address;
      logic       read_not_write;
      logic [4:0] transfer_length;
      logic [3:0] buffer_slot;
      logic [7:0] byte_value;
      logic [7:0] status_code;
   } bus_request_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // req channel, known from time zero
   logic       req_valid           = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode            = '0;
   logic [6:0] req_dev_address     = '0;
   logic       req_read_not_write  = 1'b0;
   logic [4:0] req_transfer_length = '0;
   logic [3:0] req_buffer_slot     = '0;
   logic [7:0] req_byte_value      = '0;
   logic [7:0] req_status_code     = '0;

   // rsp channel
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_accepted;
   logic [2:0] rsp_bus_action;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic [1:0] rsp_event_res;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_byte;
   logic       rsp_last;

   // csr channel
   logic csr_valid         = 1'b0;
   logic csr_ready;
   logic csr_callback_mode = 1'b0;

   // items waiting for the driver, and response items still owed by the block
   bus_request_type pending_reqs[$];
   rsp_type         predicted_responses[$];

   int error_count  = 0;
   int req_accepts  = 0;
   int queued_total = 0;
   int idle_cycles  = 0;

   // predicted sequencer state
   phase_type  seq_phase    = PH_READY;
   logic [7:0] seq_store [BUFFER_DEPTH];
   int         seq_position = 0;
   int         seq_count    = 0;
   logic [7:0] seq_addr_rw  = '0;
   logic       seq_callback = 1'b0;

   i2c_master_transaction_sequencer #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_dev_address    (req_dev_address),
      .req_read_not_write (req_read_not_write),
      .req_transfer_length(req_transfer_length),
      .req_buffer_slot    (req_buffer_slot),
      .req_byte_value     (req_byte_value),
      .req_status_code    (req_status_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_bus_action     (rsp_bus_action),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_event_res      (rsp_event_res),
      .rsp_rx_valid       (rsp_rx_valid),
      .rsp_rx_byte        (rsp_rx_byte),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_callback_mode  (csr_callback_mode)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // completion events only show up in callback mode
   function automatic ev_type completion_event(input ev_type ev);
      return seq_callback ? ev : EV_NONE;
   endfunction

   // received byte, dropped once the buffer is full
   task automatic store_received(input logic [7:0] value);
      if (seq_position < BUFFER_DEPTH) begin
         seq_store[seq_position] = value;
         seq_position++;
      end
   endtask

   task automatic predict_sequencer_step(input bus_request_type r);
      rsp_type    res;
      logic [7:0] code;
      int         n;
      bit         dumped;
      res      = '0;
      res.last = 1'b1;
      dumped   = 1'b0;
      // prescaler bits carry no meaning
      code     = r.status_code & STATUS_MASK;
      case (r.mode)
         MODE_LOAD: begin
            if (seq_phase == PH_READY && r.buffer_slot < BUFFER_DEPTH) begin
               seq_store[r.buffer_slot] = r.byte_value;
               res.accepted = 1'b1;
            end
         end
         MODE_START: begin
            // refused while busy or when longer than the buffer
            if (seq_phase == PH_READY && r.transfer_length <= BUFFER_DEPTH) begin
               seq_phase      = r.read_not_write ? PH_RECEIVE : PH_TRANSMIT;
               seq_position   = 0;
               seq_count      = r.transfer_length;
               seq_addr_rw    = {r.dev_address, r.read_not_write};
               res.accepted   = 1'b1;
               res.bus_action = ACT_START;
            end
         end
         MODE_STATUS: begin
            // status events act in any phase
            case (code)
               TWI_START, TWI_REP_START: begin
                  res.bus_action = ACT_ACK;
                  res.tx_valid   = 1'b1;
                  res.tx_byte    = seq_addr_rw;
               end
               TWI_MT_SLA_ACK, TWI_MT_DATA_ACK: begin
                  if (seq_position < seq_count && seq_position < BUFFER_DEPTH) begin
                     res.bus_action = ACT_ACK;
                     res.tx_valid   = 1'b1;
                     res.tx_byte    = seq_store[seq_position];
                     seq_position++;
                  end else begin
                     seq_phase      = PH_READY;
                     res.bus_action = ACT_STOP;
                     res.event_res  = completion_event(EV_WRITE);
                  end
               end
               TWI_MT_SLA_NACK, TWI_MT_DATA_NACK: begin
                  seq_phase      = PH_READY;
                  res.bus_action = ACT_STOP;
                  res.event_res  = completion_event(EV_WRITE);
               end
               TWI_ARB_LOST: begin
                  // reported as write done even in the middle of a read
                  seq_phase      = PH_READY;
                  res.bus_action = ACT_RELEASE;
                  res.event_res  = completion_event(EV_WRITE);
               end
               TWI_MR_SLA_ACK, TWI_MR_DATA_ACK: begin
                  if (code == TWI_MR_DATA_ACK)
                     store_received(r.byte_value);
                  // the final byte of a read gets a nack
                  res.bus_action = (seq_position + 1 < seq_count) ? ACT_ACK : ACT_NACK;
               end
               TWI_MR_SLA_NACK: begin
                  seq_phase      = PH_READY;
                  res.bus_action = ACT_STOP;
                  res.event_res  = completion_event(EV_READ_FAIL);
               end
               TWI_MR_DATA_NACK: begin
                  store_received(r.byte_value);
                  seq_phase = PH_READY;
                  n = seq_count;
                  if (n > BUFFER_DEPTH) n = BUFFER_DEPTH;
                  if (n > MAX_RESULTS) n = MAX_RESULTS;
                  if (n == 0) begin
                     res.bus_action = ACT_STOP;
                     res.event_res  = completion_event(EV_READ_OK);
                  end else begin
                     // buffer dump, stop and event ride on the first byte
                     dumped = 1'b1;
                     for (int k = 0; k < n; k++) begin
                        res = '0;
                        if (k == 0) begin
                           res.bus_action = ACT_STOP;
                           res.event_res  = completion_event(EV_READ_OK);
                        end
                        res.rx_valid = 1'b1;
                        res.rx_byte  = seq_store[k];
                        res.last     = (k == n - 1);
                        predicted_responses.push_back(res);
                     end
                  end
               end
               TWI_BUS_ERROR: begin
                  seq_phase      = PH_READY;
                  res.bus_action = ACT_STOP;
               end
               default: begin
                  // unknown code, nothing to do
               end
            endcase
         end
         default: begin
            // unused mode gives an item with only last set
         end
      endcase
      if (!dumped)
         predicted_responses.push_back(res);
   endtask

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_response();
      rsp_type want;
      if (predicted_responses.size() == 0) begin
         error_count++;
         $display("%0t: response item with none expected, expected nothing, actual %0h %0h",
                  $time, rsp_bus_action, rsp_rx_byte);
      end else begin
         want = predicted_responses.pop_front();
         check_field("accepted",   want.accepted,   rsp_accepted);
         check_field("bus_action", want.bus_action, rsp_bus_action);
         check_field("tx_valid",   want.tx_valid,   rsp_tx_valid);
         check_field("tx_byte",    want.tx_byte,    rsp_tx_byte);
         check_field("event_res",  want.event_res,  rsp_event_res);
         check_field("rx_valid",   want.rx_valid,   rsp_rx_valid);
         check_field("rx_byte",    want.rx_byte,    rsp_rx_byte);
         check_field("last",       want.last,       rsp_last);
      end
   endtask

   // monitor: everything sampled at the rising edge
   bus_request_type seen_req;

   always @(posedge clock) begin
      if (!reset) begin
         // callback mode only changes while nothing is in flight
         if (csr_valid && csr_ready)
            seq_callback = csr_callback_mode;
         if (req_valid && !req_stall) begin
            seen_req.mode            = req_mode;
            seen_req.dev_address     = req_dev_address;
            seen_req.read_not_write  = req_read_not_write;
            seen_req.transfer_length = req_transfer_length;
            seen_req.buffer_slot     = req_buffer_slot;
            seen_req.byte_value      = req_byte_value;
            seen_req.status_code     = req_status_code;
            predict_sequencer_step(seen_req);
            req_accepts++;
         end
         if (rsp_valid && !rsp_stall)
            check_response();
         // watchdog on cycles with no handshake anywhere
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // driver: bursts of items with random gaps, payload held until taken
   // ------------------------------------------------------------------------
   bus_request_type drive_req;
   int burst_left   = 4;
   int gap_left     = 0;
   int accepts_seen = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepts != accepts_seen) begin
         accepts_seen = req_accepts;
         if (gap_left > 0 || pending_reqs.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_valid <= 1'b0;
         end else begin
            drive_req = pending_reqs.pop_front();
            req_mode            <= drive_req.mode;
            req_dev_address     <= drive_req.dev_address;
            req_read_not_write  <= drive_req.read_not_write;
            req_transfer_length <= drive_req.transfer_length;
            req_buffer_slot     <= drive_req.buffer_slot;
            req_byte_value      <= drive_req.byte_value;
            req_status_code     <= drive_req.status_code;
            req_valid           <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               // a third of the bursts run straight into the next one
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // receiver: stall style is redrawn at random at regular intervals
   stall_style_type stall_style = STALL_NONE;
   int              stall_tick  = 0;

   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 48 == 0)
         stall_style = stall_style_type'($urandom_range(0, 3));
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((stall_tick % 7) < 3);
      endcase
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   task automatic queue_req(input bus_request_type r);
      pending_reqs.push_back(r);
      queued_total++;
   endtask

   // fields the mode ignores get random values
   function automatic bus_request_type random_fields();
      bus_request_type r;
      r.mode            = 2'($urandom_range(0, 3));
      r.dev_address     = 7'($urandom);
      r.read_not_write  = 1'($urandom);
      r.transfer_length = 5'($urandom);
      r.buffer_slot     = 4'($urandom);
      r.byte_value      = 8'($urandom);
      r.status_code     = 8'($urandom);
      return r;
   endfunction

   function automatic bus_request_type load_item(input logic [3:0] slot,
                                                 input logic [7:0] value);
      bus_request_type r;
      r             = random_fields();
      r.mode        = MODE_LOAD;
      r.buffer_slot = slot;
      r.byte_value  = value;
      return r;
   endfunction

   function automatic bus_request_type start_item(input logic [6:0] addr,
                                                  input logic rnw,
                                                  input logic [4:0] len);
      bus_request_type r;
      r                 = random_fields();
      r.mode            = MODE_START;
      r.dev_address     = addr;
      r.read_not_write  = rnw;
      r.transfer_length = len;
      return r;
   endfunction

   // status with random prescaler bits and a random received byte
   function automatic bus_request_type status_item(input logic [7:0] code);
      bus_request_type r;
      r             = random_fields();
      r.mode        = MODE_STATUS;
      r.status_code = code | 8'($urandom_range(0, 7));
      return r;
   endfunction

   // mostly short transfers, with empty and full-buffer ones mixed in
   function automatic int pick_length();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return BUFFER_DEPTH;
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   task automatic queue_directed_cases();
      bus_request_type r;
      // fill the whole buffer first so no later read hits an unwritten entry
      for (int k = 0; k < BUFFER_DEPTH; k++)
         queue_req(load_item(4'(k),
                             (k == 0) ? 8'h00 : (k == BUFFER_DEPTH - 1) ? 8'hFF : 8'($urandom)));
      // unused mode with every other field at its top value
      r.mode            = MODE_UNUSED;
      r.dev_address     = 7'h7F;
      r.read_not_write  = 1'b1;
      r.transfer_length = 5'h1F;
      r.buffer_slot     = 4'hF;
      r.byte_value      = 8'hFF;
      r.status_code     = 8'hFF;
      queue_req(r);
      // one byte too long, refused
      queue_req(start_item(7'h7F, 1'b0, 5'(BUFFER_DEPTH + 1)));
      // two byte write, with a load and a start while busy
      queue_req(start_item(7'h7F, 1'b0, 5'd2));
      queue_req(load_item(4'hF, 8'hA5));
      queue_req(start_item(7'h00, 1'b1, 5'd1));
      queue_req(status_item(TWI_START));
      queue_req(status_item(TWI_MT_SLA_ACK));
      queue_req(status_item(TWI_MT_DATA_ACK));
      queue_req(status_item(TWI_MT_DATA_ACK));
      // two byte read, ack then nack, then the dump
      queue_req(start_item(7'h00, 1'b1, 5'd2));
      queue_req(status_item(TWI_REP_START));
      queue_req(status_item(TWI_MR_SLA_ACK));
      queue_req(status_item(TWI_MR_DATA_ACK));
      queue_req(status_item(TWI_MR_DATA_NACK));
      // endings and odd codes outside any transfer
      queue_req(status_item(TWI_MR_SLA_NACK));
      queue_req(status_item(TWI_MT_SLA_NACK));
      queue_req(status_item(TWI_MT_DATA_NACK));
      queue_req(status_item(TWI_ARB_LOST));
      queue_req(status_item(TWI_BUS_ERROR));
      queue_req(status_item(TWI_NO_INFO));
   endtask

   task automatic queue_random_traffic(input int n_items);
      int first_total;
      int kind;
      int len;
      int ending;
      int extra;
      first_total = queued_total;
      while (queued_total - first_total < n_items) begin
         kind   = $urandom_range(0, 9);
         ending = $urandom_range(0, 7);
         if (kind <= 3) begin
            // write transfer, sometimes cut short by a nack or lost arbitration
            repeat ($urandom_range(0, 3))
               queue_req(load_item(4'($urandom), 8'($urandom)));
            len = pick_length();
            queue_req(start_item(7'($urandom), 1'b0, 5'(len)));
            queue_req(status_item($urandom_range(0, 1) ? TWI_START : TWI_REP_START));
            if (ending == 0) begin
               queue_req(status_item(TWI_MT_SLA_NACK));
            end else begin
               queue_req(status_item(TWI_MT_SLA_ACK));
               for (int k = 0; k < len; k++)
                  queue_req(status_item((ending == 1 && k == len - 1) ?
                                        TWI_MT_DATA_NACK : TWI_MT_DATA_ACK));
               if (ending == 2)
                  queue_req(status_item(TWI_ARB_LOST));
            end
         end else if (kind <= 6) begin
            // read transfer, sometimes with surplus bytes past the transfer length
            len = pick_length();
            queue_req(start_item(7'($urandom), 1'b1, 5'(len)));
            queue_req(status_item($urandom_range(0, 1) ? TWI_START : TWI_REP_START));
            if (ending == 0) begin
               queue_req(status_item(TWI_MR_SLA_NACK));
            end else begin
               queue_req(status_item(TWI_MR_SLA_ACK));
               extra = (ending == 1) ? $urandom_range(1, 4) : 0;
               for (int k = 1; k < len + extra; k++)
                  queue_req(status_item(TWI_MR_DATA_ACK));
               queue_req(status_item((ending == 2) ? TWI_ARB_LOST : TWI_MR_DATA_NACK));
            end
         end else if (kind <= 8) begin
            // noise: any mode, any code
            queue_req(random_fields());
         end else begin
            // start with a length the buffer cannot hold
            queue_req(start_item(7'($urandom), 1'($urandom),
                                 5'($urandom_range(BUFFER_DEPTH + 1, 31))));
         end
      end
   endtask

   task automatic write_callback_mode(input logic value);
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_callback_mode <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender holds off until every owed response item is in, then lets the
   // pipeline settle
   task automatic wait_until_idle();
      while (pending_reqs.size() != 0 || req_valid || predicted_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // main sequence: directed cases in callback mode, then random traffic
   // alternating between blocking and callback mode
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_callback_mode(1'b1);
      queue_directed_cases();
      wait_until_idle();
      for (int setting = 0; setting < 4; setting++) begin
         write_callback_mode(1'(setting % 2));
         queue_random_traffic(ITEMS_PER_SETTING);
         wait_until_idle();
      end
      if (error_count == 0 && predicted_responses.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
